[design/qhgp_pkg.sv]
// Shared constants, types and helpers for the quad homography grid projector.
// Used by the multiply-accumulate unit, the divider and the top level.
// No dependencies.
package qhgp_pkg;

    localparam int MAX_COLS   = 8;
    localparam int MAX_ROWS   = 8;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_W      = 21;
    localparam int SIZE_W     = 4;
    localparam int IDX_W      = $clog2(MAX_COLS);
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 48;
    localparam int DIV_W      = ACC_W + OUT_W;
    localparam int DCNT_W     = $clog2(OUT_W);

    localparam logic ADDR_COLS = 1'b0;
    localparam logic ADDR_ROWS = 1'b1;

    typedef logic signed [MUL_W-1:0]  mul_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic        [DIV_W-1:0]  div_t;
    typedef logic        [OUT_W-1:0]  quot_t;
    typedef logic [COORD_BITS-1:0]    coord_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [SIZE_W-1:0]        size_t;

    // Grid size register value limited to the range 2..hi.
    function automatic size_t clamp_size(input size_t v, input size_t hi);
        size_t r;
        if (v < size_t'(2))
            r = size_t'(2);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

[design/qhgp_mac.sv]
// Shared signed multiply-accumulate unit of the grid projector.
// Depends on qhgp_pkg for the operand and accumulator types.
module qhgp_mac (
    input  logic           clk,
    input  logic           en,
    input  logic           first,
    input  logic           sub,
    input  qhgp_pkg::mul_t a,
    input  qhgp_pkg::mul_t b,
    output qhgp_pkg::acc_t sum
);

    qhgp_pkg::prod_t prod;
    qhgp_pkg::acc_t  term;
    qhgp_pkg::acc_t  base;
    qhgp_pkg::acc_t  acc_reg;

    assign prod = a * b;
    assign term = qhgp_pkg::acc_t'(prod);
    assign base = first ? qhgp_pkg::acc_t'(0) : acc_reg;
    assign sum  = sub ? base - term : base + term;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= sum;
        end
    end

endmodule

[design/qhgp_div.sv]
// Radix-2 restoring divider giving a rounded, saturated fixed-point quotient.
// Depends on qhgp_pkg for widths and types.
module qhgp_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  qhgp_pkg::acc_t num,
    input  qhgp_pkg::acc_t den,
    output logic           done,
    output qhgp_pkg::quot_t quot
);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_FIN  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [qhgp_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    qhgp_pkg::div_t                rem_reg, rem_next;
    qhgp_pkg::div_t                dsh_reg, dsh_next;
    logic [qhgp_pkg::ACC_W-1:0]    um_reg, um_next;
    qhgp_pkg::quot_t               q_reg, q_next;
    qhgp_pkg::quot_t               quot_reg, quot_next;
    logic                          neg_reg, neg_next;
    logic                          sat_reg, sat_next;

    logic [qhgp_pkg::ACC_W-1:0]    un;
    logic [qhgp_pkg::ACC_W-1:0]    um;
    qhgp_pkg::div_t                rem_init;
    logic                          ge;
    logic                          rnd;
    logic [qhgp_pkg::OUT_W:0]      v;
    logic [qhgp_pkg::OUT_W:0]      lim;

    assign done = done_reg;
    assign quot = quot_reg;

    always_comb
    begin
        un = num[qhgp_pkg::ACC_W-1] ? qhgp_pkg::ACC_W'(-num) : qhgp_pkg::ACC_W'(num);
        um = den[qhgp_pkg::ACC_W-1] ? qhgp_pkg::ACC_W'(-den) : qhgp_pkg::ACC_W'(den);
        rem_init = qhgp_pkg::div_t'(un) << qhgp_pkg::FRAC_BITS;
        ge  = rem_reg >= dsh_reg;
        rnd = {rem_reg, 1'b0} >= (qhgp_pkg::DIV_W + 1)'(um_reg);
        lim = {2'b01, {(qhgp_pkg::OUT_W - 1){1'b0}}} -
              (qhgp_pkg::OUT_W + 1)'(!neg_reg);
        v   = (qhgp_pkg::OUT_W + 1)'(q_reg) + (qhgp_pkg::OUT_W + 1)'(rnd);
        if (sat_reg || (v > lim))
        begin
            v = lim;
        end

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        um_next    = um_reg;
        q_next     = q_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;

        if (start)
        begin
            neg_next   = num[qhgp_pkg::ACC_W-1] ^ den[qhgp_pkg::ACC_W-1];
            um_next    = um;
            rem_next   = rem_init;
            sat_next   = rem_init >= (qhgp_pkg::div_t'(um) << qhgp_pkg::OUT_W);
            dsh_next   = qhgp_pkg::div_t'(um) << (qhgp_pkg::OUT_W - 1);
            q_next     = '0;
            cnt_next   = qhgp_pkg::DCNT_W'(qhgp_pkg::OUT_W - 1);
            state_next = DV_RUN;
        end
        else
        begin
            case (state_reg)
                DV_RUN:
                begin
                    if (ge)
                    begin
                        rem_next = rem_reg - dsh_reg;
                    end
                    q_next   = {q_reg[qhgp_pkg::OUT_W-2:0], ge};
                    dsh_next = dsh_reg >> 1;
                    if (cnt_reg == '0)
                        state_next = DV_FIN;
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
                DV_FIN:
                begin
                    quot_next  = neg_reg ? qhgp_pkg::OUT_W'(-v) : qhgp_pkg::OUT_W'(v);
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                default:
                begin
                    state_next = DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        um_reg   <= um_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
    end

endmodule

[design/quad_homography_grid_projector_core.sv]
// Top level of the quad homography grid projector: sequencer, registers, ports.
// Depends on qhgp_pkg, qhgp_mac and qhgp_div.
//
// One input beat on s_axis carries four corners of a quadrilateral. The block
// takes one beat at a time; s_axis_tready is high only while it is idle. If all
// four corner x values are zero, the beat produces nothing and the block is
// ready again in the next cycle. Otherwise a 49-step setup runs on one shared
// 32x32 multiply-accumulate unit (one product per cycle) and builds the
// homography and its grid increments. Then every grid point, row by row, is
// divided through one shared radix-2 divider, first x and then y. Degenerate
// points skip the divider. Each m_axis beat stays in its output register while
// m_axis_tready is low; the sequencer waits there. The final point carries
// m_axis_tlast. Grid sizes are to be written over the APB port by the user
// only while idle; the block itself does not enforce it. Reset sets both grid
// sizes to 8 and empties the block.
module quad_homography_grid_projector_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // c00_x, c00_y, c10_x, c10_y, c11_x, c11_y, c01_x, c01_y (12 bits each)
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // grid_x (21), grid_y (21), col_index (3), row_index (3)
    output logic [47:0] m_axis_tdata,
    // degenerate
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_DIVX  = 3'd3;
    localparam logic [2:0] ST_DIVY  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [3:0] M_LA  = 4'd0;
    localparam logic [3:0] M_LB  = 4'd1;
    localparam logic [3:0] M_MA  = 4'd2;
    localparam logic [3:0] M_MB  = 4'd3;
    localparam logic [3:0] M_C1A = 4'd4;
    localparam logic [3:0] M_C1B = 4'd5;
    localparam logic [3:0] M_C2A = 4'd6;
    localparam logic [3:0] M_C2B = 4'd7;
    localparam logic [3:0] M_C3A = 4'd8;
    localparam logic [3:0] M_C3B = 4'd9;

    localparam logic [5:0] SQ_MEET2 = 6'd10;
    localparam logic [5:0] SQ_MAIN  = 6'd20;
    localparam logic [5:0] SQ_X1A = 6'd20;
    localparam logic [5:0] SQ_X1B = 6'd21;
    localparam logic [5:0] SQ_O1A = 6'd22;
    localparam logic [5:0] SQ_O1B = 6'd23;
    localparam logic [5:0] SQ_X2A = 6'd24;
    localparam logic [5:0] SQ_X2B = 6'd25;
    localparam logic [5:0] SQ_O2A = 6'd26;
    localparam logic [5:0] SQ_O2B = 6'd27;
    localparam logic [5:0] SQ_DNA = 6'd28;
    localparam logic [5:0] SQ_DNB = 6'd29;
    localparam logic [5:0] SQ_GA  = 6'd30;
    localparam logic [5:0] SQ_GB  = 6'd31;
    localparam logic [5:0] SQ_HA  = 6'd32;
    localparam logic [5:0] SQ_HB  = 6'd33;
    localparam logic [5:0] SQ_DR  = 6'd34;
    localparam logic [5:0] SQ_DC  = 6'd35;
    localparam logic [5:0] SQ_DK  = 6'd36;
    localparam logic [5:0] SQ_GR  = 6'd37;
    localparam logic [5:0] SQ_HC  = 6'd38;
    localparam logic [5:0] SQ_AXA = 6'd39;
    localparam logic [5:0] SQ_AXB = 6'd40;
    localparam logic [5:0] SQ_BXA = 6'd41;
    localparam logic [5:0] SQ_BXB = 6'd42;
    localparam logic [5:0] SQ_CX  = 6'd43;
    localparam logic [5:0] SQ_AYA = 6'd44;
    localparam logic [5:0] SQ_AYB = 6'd45;
    localparam logic [5:0] SQ_BYA = 6'd46;
    localparam logic [5:0] SQ_BYB = 6'd47;
    localparam logic [5:0] SQ_CY  = 6'd48;

    logic [2:0]              state_reg, state_next;
    logic [5:0]              step_reg, step_next;
    qhgp_pkg::idx_t          i_reg, i_next;
    qhgp_pkg::idx_t          j_reg, j_next;
    qhgp_pkg::size_t         cols_reg, cols_next;
    qhgp_pkg::size_t         rows_reg, rows_next;

    qhgp_pkg::coord_t        x_reg [4];
    qhgp_pkg::coord_t        y_reg [4];
    logic                    bad_reg, bad_next;
    logic                    zflag_reg, zflag_next;
    qhgp_pkg::mul_t          t0_reg, t0_next;
    qhgp_pkg::mul_t          t1_reg, t1_next;
    qhgp_pkg::mul_t          den_reg, den_next;
    qhgp_pkg::mul_t          g_reg, g_next;
    qhgp_pkg::mul_t          h_reg, h_next;
    qhgp_pkg::mul_t          den_r_reg, den_r_next;
    qhgp_pkg::mul_t          den_c_reg, den_c_next;
    qhgp_pkg::mul_t          den_k_reg, den_k_next;
    qhgp_pkg::mul_t          g_r_reg, g_r_next;
    qhgp_pkg::mul_t          h_c_reg, h_c_next;
    qhgp_pkg::acc_t          ax_reg, ax_next;
    qhgp_pkg::acc_t          bx_reg, bx_next;
    qhgp_pkg::acc_t          ay_reg, ay_next;
    qhgp_pkg::acc_t          by_reg, by_next;
    qhgp_pkg::acc_t          row_wx_reg, row_wx_next;
    qhgp_pkg::acc_t          row_wy_reg, row_wy_next;
    qhgp_pkg::acc_t          row_ww_reg, row_ww_next;
    qhgp_pkg::acc_t          cur_wx_reg, cur_wx_next;
    qhgp_pkg::acc_t          cur_wy_reg, cur_wy_next;
    qhgp_pkg::acc_t          cur_ww_reg, cur_ww_next;
    qhgp_pkg::quot_t         out_x_reg, out_x_next;
    qhgp_pkg::quot_t         out_y_reg, out_y_next;
    logic                    deg_reg, deg_next;

    qhgp_pkg::coord_t        in_x [4];
    qhgp_pkg::coord_t        in_y [4];
    qhgp_pkg::mul_t          xm [4];
    qhgp_pkg::mul_t          ym [4];
    qhgp_pkg::mul_t          dd [4];
    qhgp_pkg::mul_t          ee [4];
    qhgp_pkg::mul_t          sx, sy;
    qhgp_pkg::mul_t          xb, yb, xc, yc;
    qhgp_pkg::mul_t          l0, l1, m0, m1;
    qhgp_pkg::mul_t          dx1, dx2, dy1, dy2, zx, zy;
    qhgp_pkg::mul_t          cm_m, rm_m, kk_m;
    qhgp_pkg::idx_t          cm, rm;
    logic [5:0]              kk;
    logic                    pass2;
    logic [3:0]              meet_step;

    qhgp_pkg::mul_t          mac_a, mac_b;
    logic                    mac_first, mac_sub, mac_en;
    qhgp_pkg::acc_t          mac_sum;
    logic                    sum_zero;

    logic                    div_start;
    qhgp_pkg::acc_t          div_num;
    logic                    div_done;
    qhgp_pkg::quot_t         div_quot;

    logic                    in_acc, out_acc, cfg_wr;
    logic                    last_pt;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {j_reg, i_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = deg_reg;
    assign m_axis_tlast  = last_pt;

    always_comb
    begin
        prdata = (paddr[2] == qhgp_pkg::ADDR_ROWS) ? 32'(rows_reg) : 32'(cols_reg);
    end

    always_comb
    begin
        cm = qhgp_pkg::IDX_W'(qhgp_pkg::clamp_size(cols_reg,
                 qhgp_pkg::SIZE_W'(qhgp_pkg::MAX_COLS)) - 1'b1);
        rm = qhgp_pkg::IDX_W'(qhgp_pkg::clamp_size(rows_reg,
                 qhgp_pkg::SIZE_W'(qhgp_pkg::MAX_ROWS)) - 1'b1);
        kk = 6'(cm) * 6'(rm);
        cm_m = qhgp_pkg::mul_t'(cm);
        rm_m = qhgp_pkg::mul_t'(rm);
        kk_m = qhgp_pkg::mul_t'(kk);
        last_pt = (i_reg == cm) && (j_reg == rm);
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            in_x[k] = s_axis_tdata[24*k +: 12];
            in_y[k] = s_axis_tdata[24*k + 12 +: 12];
            xm[k]   = qhgp_pkg::mul_t'(x_reg[k]);
            ym[k]   = qhgp_pkg::mul_t'(y_reg[k]);
        end
        sx = xm[0] + xm[1] + xm[2] + xm[3];
        sy = ym[0] + ym[1] + ym[2] + ym[3];
        for (int k = 0; k < 4; k++)
        begin
            dd[k] = (xm[k] <<< 2) - sx;
            ee[k] = (ym[k] <<< 2) - sy;
        end
        pass2 = (step_reg >= SQ_MEET2);
        meet_step = pass2 ? 4'(step_reg - SQ_MEET2) : step_reg[3:0];
        xb = pass2 ? xm[3] : xm[1];
        yb = pass2 ? ym[3] : ym[1];
        xc = pass2 ? xm[1] : xm[3];
        yc = pass2 ? ym[1] : ym[3];
        l0 = ym[0] - yb;
        l1 = xb - xm[0];
        m0 = yc - ym[2];
        m1 = xm[2] - xc;
        dx1 = xm[1] - xm[2];
        dx2 = xm[3] - xm[2];
        dy1 = ym[1] - ym[2];
        dy2 = ym[3] - ym[2];
        zx  = xm[0] - xm[1] + xm[2] - xm[3];
        zy  = ym[0] - ym[1] + ym[2] - ym[3];
    end

    always_comb
    begin
        mac_a     = '0;
        mac_b     = '0;
        mac_first = 1'b1;
        mac_sub   = 1'b0;
        if (step_reg < SQ_MAIN)
        begin
            case (meet_step)
                M_LA:  begin mac_a = xm[0]; mac_b = yb; end
                M_LB:  begin mac_a = ym[0]; mac_b = xb; mac_first = 1'b0; mac_sub = 1'b1; end
                M_MA:  begin mac_a = xc; mac_b = ym[2]; end
                M_MB:  begin mac_a = yc; mac_b = xm[2]; mac_first = 1'b0; mac_sub = 1'b1; end
                M_C1A: begin mac_a = l1; mac_b = t1_reg; end
                M_C1B: begin mac_a = t0_reg; mac_b = m1; mac_first = 1'b0; mac_sub = 1'b1; end
                M_C2A: begin mac_a = t0_reg; mac_b = m0; end
                M_C2B: begin mac_a = l0; mac_b = t1_reg; mac_first = 1'b0; mac_sub = 1'b1; end
                M_C3A: begin mac_a = l0; mac_b = m1; end
                M_C3B: begin mac_a = l1; mac_b = m0; mac_first = 1'b0; mac_sub = 1'b1; end
                default: begin mac_a = '0; mac_b = '0; end
            endcase
        end
        else
        begin
            case (step_reg)
                SQ_X1A: begin mac_a = dd[0]; mac_b = ee[1]; end
                SQ_X1B: begin mac_a = ee[0]; mac_b = dd[1]; mac_first = 1'b0; mac_sub = 1'b1; end
                SQ_O1A: begin mac_a = xm[2] - xm[3]; mac_b = ym[1] - ym[3]; end
                SQ_O1B:
                begin
                    mac_a = ym[2] - ym[3];
                    mac_b = xm[1] - xm[3];
                    mac_first = 1'b0;
                    mac_sub = 1'b1;
                end
                SQ_X2A: begin mac_a = dd[0]; mac_b = ee[3]; end
                SQ_X2B: begin mac_a = ee[0]; mac_b = dd[3]; mac_first = 1'b0; mac_sub = 1'b1; end
                SQ_O2A: begin mac_a = xm[2] - xm[1]; mac_b = ym[3] - ym[1]; end
                SQ_O2B:
                begin
                    mac_a = ym[2] - ym[1];
                    mac_b = xm[3] - xm[1];
                    mac_first = 1'b0;
                    mac_sub = 1'b1;
                end
                SQ_DNA: begin mac_a = dx1; mac_b = dy2; end
                SQ_DNB: begin mac_a = dx2; mac_b = dy1; mac_first = 1'b0; mac_sub = 1'b1; end
                SQ_GA:  begin mac_a = zx; mac_b = dy2; end
                SQ_GB:  begin mac_a = dx2; mac_b = zy; mac_first = 1'b0; mac_sub = 1'b1; end
                SQ_HA:  begin mac_a = dx1; mac_b = zy; end
                SQ_HB:  begin mac_a = zx; mac_b = dy1; mac_first = 1'b0; mac_sub = 1'b1; end
                SQ_DR:  begin mac_a = den_reg; mac_b = rm_m; end
                SQ_DC:  begin mac_a = den_reg; mac_b = cm_m; end
                SQ_DK:  begin mac_a = den_reg; mac_b = kk_m; end
                SQ_GR:  begin mac_a = g_reg; mac_b = rm_m; end
                SQ_HC:  begin mac_a = h_reg; mac_b = cm_m; end
                SQ_AXA: begin mac_a = xm[1] - xm[0]; mac_b = den_r_reg; end
                SQ_AXB: begin mac_a = g_r_reg; mac_b = xm[1]; mac_first = 1'b0; end
                SQ_BXA: begin mac_a = xm[3] - xm[0]; mac_b = den_c_reg; end
                SQ_BXB: begin mac_a = h_c_reg; mac_b = xm[3]; mac_first = 1'b0; end
                SQ_CX:  begin mac_a = xm[0]; mac_b = den_k_reg; end
                SQ_AYA: begin mac_a = ym[1] - ym[0]; mac_b = den_r_reg; end
                SQ_AYB: begin mac_a = g_r_reg; mac_b = ym[1]; mac_first = 1'b0; end
                SQ_BYA: begin mac_a = ym[3] - ym[0]; mac_b = den_c_reg; end
                SQ_BYB: begin mac_a = h_c_reg; mac_b = ym[3]; mac_first = 1'b0; end
                SQ_CY:  begin mac_a = ym[0]; mac_b = den_k_reg; end
                default: begin mac_a = '0; mac_b = '0; end
            endcase
        end
    end

    assign mac_en   = (state_reg == ST_SETUP);
    assign sum_zero = (mac_sum == '0);

    qhgp_mac u_mac (
        .clk   (clk),
        .en    (mac_en),
        .first (mac_first),
        .sub   (mac_sub),
        .a     (mac_a),
        .b     (mac_b),
        .sum   (mac_sum)
    );

    assign div_num = (state_reg == ST_DIVX) ? cur_wy_reg : cur_wx_reg;

    qhgp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cur_ww_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        bad_next    = bad_reg;
        zflag_next  = zflag_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        den_next    = den_reg;
        g_next      = g_reg;
        h_next      = h_reg;
        den_r_next  = den_r_reg;
        den_c_next  = den_c_reg;
        den_k_next  = den_k_reg;
        g_r_next    = g_r_reg;
        h_c_next    = h_c_reg;
        ax_next     = ax_reg;
        bx_next     = bx_reg;
        ay_next     = ay_reg;
        by_next     = by_reg;
        row_wx_next = row_wx_reg;
        row_wy_next = row_wy_reg;
        row_ww_next = row_ww_reg;
        cur_wx_next = cur_wx_reg;
        cur_wy_next = cur_wy_reg;
        cur_ww_next = cur_ww_reg;
        out_x_next  = out_x_reg;
        out_y_next  = out_y_reg;
        deg_next    = deg_reg;
        div_start   = 1'b0;

        if (cfg_wr)
        begin
            if (paddr[2] == qhgp_pkg::ADDR_ROWS)
                rows_next = pwdata[qhgp_pkg::SIZE_W-1:0];
            else
                cols_next = pwdata[qhgp_pkg::SIZE_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    bad_next = ((in_x[0] == in_x[1]) && (in_x[1] == in_x[2]) &&
                                (in_x[2] == in_x[3])) ||
                               ((in_y[0] == in_y[1]) && (in_y[1] == in_y[2]) &&
                                (in_y[2] == in_y[3]));
                    step_next = '0;
                    if ((in_x[0] != '0) || (in_x[1] != '0) ||
                        (in_x[2] != '0) || (in_x[3] != '0))
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg < SQ_MAIN)
                begin
                    case (meet_step)
                        M_LA:  zflag_next = 1'b1;
                        M_LB:  t0_next = qhgp_pkg::mul_t'(mac_sum);
                        M_MB:  t1_next = qhgp_pkg::mul_t'(mac_sum);
                        M_C1B: zflag_next = zflag_reg && sum_zero;
                        M_C2B: zflag_next = zflag_reg && sum_zero;
                        M_C3B:
                        begin
                            if (zflag_reg && sum_zero)
                                bad_next = 1'b1;
                        end
                        default: zflag_next = zflag_reg;
                    endcase
                end
                else
                begin
                    case (step_reg)
                        SQ_X1B, SQ_O1B, SQ_X2B, SQ_O2B:
                        begin
                            if (sum_zero)
                                bad_next = 1'b1;
                        end
                        SQ_DNB: den_next   = qhgp_pkg::mul_t'(mac_sum);
                        SQ_GB:  g_next     = qhgp_pkg::mul_t'(mac_sum);
                        SQ_HB:  h_next     = qhgp_pkg::mul_t'(mac_sum);
                        SQ_DR:  den_r_next = qhgp_pkg::mul_t'(mac_sum);
                        SQ_DC:  den_c_next = qhgp_pkg::mul_t'(mac_sum);
                        SQ_DK:  den_k_next = qhgp_pkg::mul_t'(mac_sum);
                        SQ_GR:  g_r_next   = qhgp_pkg::mul_t'(mac_sum);
                        SQ_HC:  h_c_next   = qhgp_pkg::mul_t'(mac_sum);
                        SQ_AXB: ax_next    = mac_sum;
                        SQ_BXB: bx_next    = mac_sum;
                        SQ_AYB: ay_next    = mac_sum;
                        SQ_BYB: by_next    = mac_sum;
                        SQ_CX:
                        begin
                            row_wx_next = mac_sum;
                            cur_wx_next = mac_sum;
                        end
                        SQ_CY:
                        begin
                            row_wy_next = mac_sum;
                            cur_wy_next = mac_sum;
                            row_ww_next = qhgp_pkg::acc_t'(den_k_reg);
                            cur_ww_next = qhgp_pkg::acc_t'(den_k_reg);
                            i_next      = '0;
                            j_next      = '0;
                            state_next  = ST_PREP;
                        end
                        default: bad_next = bad_reg;
                    endcase
                end
            end
            ST_PREP:
            begin
                if (bad_reg || (cur_ww_reg == '0))
                begin
                    out_x_next = '0;
                    out_y_next = '0;
                    deg_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    deg_next   = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    out_x_next = div_quot;
                    div_start  = 1'b1;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    out_y_next = div_quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (last_pt)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                        if (i_reg == cm)
                        begin
                            i_next      = '0;
                            j_next      = j_reg + 1'b1;
                            row_wx_next = row_wx_reg + bx_reg;
                            row_wy_next = row_wy_reg + by_reg;
                            row_ww_next = row_ww_reg + qhgp_pkg::acc_t'(h_c_reg);
                            cur_wx_next = row_wx_reg + bx_reg;
                            cur_wy_next = row_wy_reg + by_reg;
                            cur_ww_next = row_ww_reg + qhgp_pkg::acc_t'(h_c_reg);
                        end
                        else
                        begin
                            i_next      = i_reg + 1'b1;
                            cur_wx_next = cur_wx_reg + ax_reg;
                            cur_wy_next = cur_wy_reg + ay_reg;
                            cur_ww_next = cur_ww_reg + qhgp_pkg::acc_t'(g_r_reg);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            cols_reg  <= qhgp_pkg::SIZE_W'(qhgp_pkg::MAX_COLS);
            rows_reg  <= qhgp_pkg::SIZE_W'(qhgp_pkg::MAX_ROWS);
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int k = 0; k < 4; k++)
            begin
                x_reg[k] <= in_x[k];
                y_reg[k] <= in_y[k];
            end
        end
        bad_reg    <= bad_next;
        zflag_reg  <= zflag_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        den_reg    <= den_next;
        g_reg      <= g_next;
        h_reg      <= h_next;
        den_r_reg  <= den_r_next;
        den_c_reg  <= den_c_next;
        den_k_reg  <= den_k_next;
        g_r_reg    <= g_r_next;
        h_c_reg    <= h_c_next;
        ax_reg     <= ax_next;
        bx_reg     <= bx_next;
        ay_reg     <= ay_next;
        by_reg     <= by_next;
        row_wx_reg <= row_wx_next;
        row_wy_reg <= row_wy_next;
        row_ww_reg <= row_ww_next;
        cur_wx_reg <= cur_wx_next;
        cur_wy_reg <= cur_wy_next;
        cur_ww_reg <= cur_ww_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        deg_reg    <= deg_next;
    end

endmodule
